// ===== src/cbs_pkg.sv =====
// Shared widths, payload types and rounding helpers for the cubic Bezier split block.
// No dependencies; used by the interfaces, cbs_axis and cubic_bezier_split.
package cbs_pkg;

	localparam int COORD_BITS  = 32;
	localparam int T_FRAC_BITS = 16;

	// split parameter and weights: unsigned Q1.16 (one integer bit, T_FRAC_BITS fraction bits)
	localparam int T_W  = T_FRAC_BITS + 1;
	// weight as a signed multiplier operand
	localparam int TS_W = T_FRAC_BITS + 2;

	// exact widths of the de Casteljau levels (convex sums never grow past these)
	localparam int A_W = COORD_BITS + T_FRAC_BITS;
	localparam int B_W = COORD_BITS + 2 * T_FRAC_BITS;
	localparam int C_W = COORD_BITS + 3 * T_FRAC_BITS;

	localparam logic [T_W-1:0] T_ONE  = T_W'(1) << T_FRAC_BITS;
	localparam logic [A_W-1:0] HALF_A = A_W'(1) << (T_FRAC_BITS - 1);
	localparam logic [B_W-1:0] HALF_B = B_W'(1) << (2 * T_FRAC_BITS - 1);
	localparam logic [C_W-1:0] HALF_C = C_W'(1) << (3 * T_FRAC_BITS - 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [T_W-1:0]               frac_t;
	typedef logic signed [A_W-1:0]        lvl_a_t;
	typedef logic signed [B_W-1:0]        lvl_b_t;
	typedef logic signed [C_W-1:0]        lvl_c_t;

	typedef struct packed {
		coord_t p0_x;
		coord_t p0_y;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p3_x;
		coord_t p3_y;
		frac_t  split_at;
	} pts_t;

	typedef struct packed {
		coord_t q0_x;
		coord_t q0_y;
		coord_t q1_x;
		coord_t q1_y;
		coord_t q2_x;
		coord_t q2_y;
		coord_t q3_x;
		coord_t q3_y;
		logic   is_right_half;
	} part_t;

	// one axis leaving the arithmetic pipeline; the midpoint is still unrounded
	typedef struct packed {
		coord_t p0;
		coord_t a01;
		coord_t b012;
		lvl_c_t c;
		coord_t b123;
		coord_t a23;
		coord_t p3;
	} axis_res_t;

	// one axis of both sub-curves, all rounded
	typedef struct packed {
		coord_t p0;
		coord_t a01;
		coord_t b012;
		coord_t mid;
		coord_t b123;
		coord_t a23;
		coord_t p3;
	} axis_pts_t;

	// round to nearest, ties up, then drop the fraction bits
	function automatic coord_t rnd_a(input lvl_a_t v);
		logic [A_W-1:0] s;
		s = v + HALF_A;
		return s[A_W-1:T_FRAC_BITS];
	endfunction

	function automatic coord_t rnd_b(input lvl_b_t v);
		logic [B_W-1:0] s;
		s = v + HALF_B;
		return s[B_W-1:2*T_FRAC_BITS];
	endfunction

	function automatic coord_t rnd_c(input lvl_c_t v);
		logic [C_W-1:0] s;
		s = v + HALF_C;
		return s[C_W-1:3*T_FRAC_BITS];
	endfunction

endpackage

// ===== src/cbs_if.sv =====
// Valid/ready channel interfaces for control-point input and sub-curve output.
// Depends on cbs_pkg for the payload structs.
interface cbs_pts_if;
	logic         valid;
	logic         ready;
	cbs_pkg::pts_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cbs_part_if;
	logic           valid;
	logic           ready;
	cbs_pkg::part_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/cbs_axis.sv =====
// Three-stage de Casteljau datapath for one coordinate axis (stages s2..s4).
// Depends on cbs_pkg; control and valid bits live in cubic_bezier_split.
module cbs_axis (
	input  logic               clk,
	input  logic               en,
	input  cbs_pkg::coord_t    p0,
	input  cbs_pkg::coord_t    p1,
	input  cbs_pkg::coord_t    p2,
	input  cbs_pkg::coord_t    p3,
	input  cbs_pkg::frac_t     t,
	input  cbs_pkg::frac_t     u,
	output cbs_pkg::axis_res_t res
);

	localparam int PA_W = cbs_pkg::COORD_BITS + cbs_pkg::TS_W;
	localparam int PB_W = cbs_pkg::A_W + cbs_pkg::TS_W;
	localparam int PC_W = cbs_pkg::B_W + cbs_pkg::TS_W;

	logic signed [cbs_pkg::TS_W-1:0] ws_t1, ws_u1, ws_t2, ws_u2, ws_t3, ws_u3;

	// stage 2: first level
	logic signed [PA_W-1:0] pa0u, pa1t, pa1u, pa2t, pa2u, pa3t;
	cbs_pkg::lvl_a_t        a01_s2, a12_s2, a23_s2;
	cbs_pkg::coord_t        p0_s2, p3_s2;
	cbs_pkg::frac_t         t_s2, u_s2;

	// stage 3: second level
	logic signed [PB_W-1:0] pb0u, pb1t, pb1u, pb2t;
	cbs_pkg::lvl_b_t        b012_s3, b123_s3;
	cbs_pkg::coord_t        a01_s3, a23_s3, p0_s3, p3_s3;
	cbs_pkg::frac_t         t_s3, u_s3;

	// stage 4: third level
	logic signed [PC_W-1:0] pc0u, pc1t;
	cbs_pkg::lvl_c_t        c_s4;
	cbs_pkg::coord_t        b012_s4, b123_s4, a01_s4, a23_s4, p0_s4, p3_s4;

	assign ws_t1 = $signed({1'b0, t});
	assign ws_u1 = $signed({1'b0, u});
	assign ws_t2 = $signed({1'b0, t_s2});
	assign ws_u2 = $signed({1'b0, u_s2});
	assign ws_t3 = $signed({1'b0, t_s3});
	assign ws_u3 = $signed({1'b0, u_s3});

	assign pa0u = PA_W'(p0) * PA_W'(ws_u1);
	assign pa1t = PA_W'(p1) * PA_W'(ws_t1);
	assign pa1u = PA_W'(p1) * PA_W'(ws_u1);
	assign pa2t = PA_W'(p2) * PA_W'(ws_t1);
	assign pa2u = PA_W'(p2) * PA_W'(ws_u1);
	assign pa3t = PA_W'(p3) * PA_W'(ws_t1);

	assign pb0u = PB_W'(a01_s2) * PB_W'(ws_u2);
	assign pb1t = PB_W'(a12_s2) * PB_W'(ws_t2);
	assign pb1u = PB_W'(a12_s2) * PB_W'(ws_u2);
	assign pb2t = PB_W'(a23_s2) * PB_W'(ws_t2);

	assign pc0u = PC_W'(b012_s3) * PC_W'(ws_u3);
	assign pc1t = PC_W'(b123_s3) * PC_W'(ws_t3);

	// the true sums fit each level's width, so wrap-around in the terms cancels
	always_ff @(posedge clk) begin
		if (en) begin
			a01_s2  <= cbs_pkg::A_W'(pa0u) + cbs_pkg::A_W'(pa1t);
			a12_s2  <= cbs_pkg::A_W'(pa1u) + cbs_pkg::A_W'(pa2t);
			a23_s2  <= cbs_pkg::A_W'(pa2u) + cbs_pkg::A_W'(pa3t);
			p0_s2   <= p0;
			p3_s2   <= p3;
			t_s2    <= t;
			u_s2    <= u;

			b012_s3 <= cbs_pkg::B_W'(pb0u) + cbs_pkg::B_W'(pb1t);
			b123_s3 <= cbs_pkg::B_W'(pb1u) + cbs_pkg::B_W'(pb2t);
			a01_s3  <= cbs_pkg::rnd_a(a01_s2);
			a23_s3  <= cbs_pkg::rnd_a(a23_s2);
			p0_s3   <= p0_s2;
			p3_s3   <= p3_s2;
			t_s3    <= t_s2;
			u_s3    <= u_s2;

			c_s4    <= cbs_pkg::C_W'(pc0u) + cbs_pkg::C_W'(pc1t);
			b012_s4 <= cbs_pkg::rnd_b(b012_s3);
			b123_s4 <= cbs_pkg::rnd_b(b123_s3);
			a01_s4  <= a01_s3;
			a23_s4  <= a23_s3;
			p0_s4   <= p0_s3;
			p3_s4   <= p3_s3;
		end
	end

	assign res.p0   = p0_s4;
	assign res.a01  = a01_s4;
	assign res.b012 = b012_s4;
	assign res.c    = c_s4;
	assign res.b123 = b123_s4;
	assign res.a23  = a23_s4;
	assign res.p3   = p3_s4;

endmodule

// ===== src/cubic_bezier_split.sv =====
// Cubic Bezier split top level: de Casteljau subdivision, four register stages and
// an output register that delivers the left, then the right sub-curve.
// The left sub-curve is offered after an item passes stages s1..s4 and the output
// register, the right one in the cycle after the left is taken. The single result
// channel carries two transactions per item, one per sub-curve.
// Reset clears the valid bits and the output phase; the datapath is not reset.
module cubic_bezier_split (
	input  logic              clk,
	input  logic              arst_n,
	cbs_pts_if.sink           curve,
	cbs_part_if.source        part
);

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en;
	logic out_free;
	logic load;

	// stage 1: captured control points and clamped weights
	cbs_pkg::coord_t p0x_s1, p0y_s1, p1x_s1, p1y_s1;
	cbs_pkg::coord_t p2x_s1, p2y_s1, p3x_s1, p3y_s1;
	cbs_pkg::frac_t  t_s1, u_s1;
	cbs_pkg::frac_t  t_in;

	cbs_pkg::axis_res_t xr, yr;

	// output register: both sub-curves, and which half is on offer
	logic               o_valid_q;
	logic               half_q;
	cbs_pkg::axis_pts_t xo_q, yo_q;

	// The output register frees up when it is empty or its right half leaves this
	// cycle. The whole pipeline advances whenever the last stage can drain or holds
	// a bubble, so a stall freezes every stage in place and nothing is lost.
	assign out_free    = !o_valid_q || (half_q && part.ready);
	assign en          = !v_s4 || out_free;
	assign load        = v_s4 && out_free;
	assign curve.ready = en;

	// clamp t to one; u = 1 - t is then never negative
	assign t_in = (curve.data.split_at > cbs_pkg::T_ONE) ? cbs_pkg::T_ONE
	                                                     : curve.data.split_at;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= curve.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0x_s1 <= curve.data.p0_x;
			p0y_s1 <= curve.data.p0_y;
			p1x_s1 <= curve.data.p1_x;
			p1y_s1 <= curve.data.p1_y;
			p2x_s1 <= curve.data.p2_x;
			p2y_s1 <= curve.data.p2_y;
			p3x_s1 <= curve.data.p3_x;
			p3y_s1 <= curve.data.p3_y;
			t_s1   <= t_in;
			u_s1   <= cbs_pkg::T_ONE - t_in;
		end
	end

	cbs_axis u_axis_x (
		.clk (clk),
		.en  (en),
		.p0  (p0x_s1),
		.p1  (p1x_s1),
		.p2  (p2x_s1),
		.p3  (p3x_s1),
		.t   (t_s1),
		.u   (u_s1),
		.res (xr)
	);

	cbs_axis u_axis_y (
		.clk (clk),
		.en  (en),
		.p0  (p0y_s1),
		.p1  (p1y_s1),
		.p2  (p2y_s1),
		.p3  (p3y_s1),
		.t   (t_s1),
		.u   (u_s1),
		.res (yr)
	);

	// Load a finished item, else step left -> right -> empty as transactions complete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			half_q    <= 1'b0;
		end else if (load) begin
			o_valid_q <= 1'b1;
			half_q    <= 1'b0;
		end else if (o_valid_q && part.ready) begin
			if (half_q) begin
				o_valid_q <= 1'b0;
				half_q    <= 1'b0;
			end else begin
				half_q <= 1'b1;
			end
		end
	end

	// round the curve point once here and keep it for both halves
	always_ff @(posedge clk) begin
		if (load) begin
			xo_q.p0   <= xr.p0;
			xo_q.a01  <= xr.a01;
			xo_q.b012 <= xr.b012;
			xo_q.mid  <= cbs_pkg::rnd_c(xr.c);
			xo_q.b123 <= xr.b123;
			xo_q.a23  <= xr.a23;
			xo_q.p3   <= xr.p3;
			yo_q.p0   <= yr.p0;
			yo_q.a01  <= yr.a01;
			yo_q.b012 <= yr.b012;
			yo_q.mid  <= cbs_pkg::rnd_c(yr.c);
			yo_q.b123 <= yr.b123;
			yo_q.a23  <= yr.a23;
			yo_q.p3   <= yr.p3;
		end
	end

	// Left: P0, a01, b012, B(t). Right: B(t), b123, a23, P3.
	always_comb begin
		part.valid              = o_valid_q;
		part.data.is_right_half = half_q;
		if (half_q) begin
			part.data.q0_x = xo_q.mid;
			part.data.q0_y = yo_q.mid;
			part.data.q1_x = xo_q.b123;
			part.data.q1_y = yo_q.b123;
			part.data.q2_x = xo_q.a23;
			part.data.q2_y = yo_q.a23;
			part.data.q3_x = xo_q.p3;
			part.data.q3_y = yo_q.p3;
		end else begin
			part.data.q0_x = xo_q.p0;
			part.data.q0_y = yo_q.p0;
			part.data.q1_x = xo_q.a01;
			part.data.q1_y = yo_q.a01;
			part.data.q2_x = xo_q.b012;
			part.data.q2_y = yo_q.b012;
			part.data.q3_x = xo_q.mid;
			part.data.q3_y = yo_q.mid;
		end
	end

endmodule
